>>> rtl/gtp_pkg.sv
package gtp_pkg;

	// field widths
	localparam int unsigned POS_W = 16;
	localparam int unsigned HDG_W = 15;
	localparam int unsigned VEL_W = 16;
	localparam int unsigned CFG_W = 15;
	localparam int unsigned IDX_W = 3;

	// shared multiplier operands and product
	localparam int unsigned MOP_W = 17;
	localparam int unsigned PRD_W = 34;

	// cordic datapath
	localparam int unsigned CXY_W = 34;
	localparam int unsigned CZ_W  = 28;
	localparam int unsigned ATAN_LEN = 24;
	localparam int unsigned ATAN_IDX_W = 5;
	localparam logic signed [CZ_W-1:0] ANG_PI_HALF = 28'sd26353589;

	typedef logic [1:0] mode_t;

	localparam mode_t MODE_FACE    = 2'd0;
	localparam mode_t MODE_DRIVE   = 2'd1;
	localparam mode_t MODE_ALIGN   = 2'd2;
	localparam mode_t MODE_ARRIVED = 2'd3;

	// register indexes
	localparam logic [IDX_W-1:0] REG_DIST_TOL  = 3'd0;
	localparam logic [IDX_W-1:0] REG_ANGLE_TOL = 3'd1;
	localparam logic [IDX_W-1:0] REG_FWD_GAIN  = 3'd2;
	localparam logic [IDX_W-1:0] REG_SLOW      = 3'd3;
	localparam logic [IDX_W-1:0] REG_TURN_GAIN = 3'd4;

	// register reset values
	localparam logic [14:0] RST_DIST_TOL  = 15'd205;
	localparam logic [13:0] RST_ANGLE_TOL = 14'd205;
	localparam logic [13:0] RST_FWD_GAIN  = 14'd1638;
	localparam logic [12:0] RST_SLOW      = 13'd410;
	localparam logic [13:0] RST_TURN_GAIN = 14'd4096;

	typedef struct packed {
		logic                    done;
		logic signed [VEL_W-1:0] bearing;
	} cord_res_t;

	// arctangent of 2^-i in Q.24 radians, rounded
	function automatic logic signed [CZ_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
		logic signed [CZ_W-1:0] r;
		unique case (idx)
			5'd0:  r = 28'sd13176795;
			5'd1:  r = 28'sd7778716;
			5'd2:  r = 28'sd4110060;
			5'd3:  r = 28'sd2086331;
			5'd4:  r = 28'sd1047214;
			5'd5:  r = 28'sd524117;
			5'd6:  r = 28'sd262123;
			5'd7:  r = 28'sd131069;
			5'd8:  r = 28'sd65536;
			5'd9:  r = 28'sd32768;
			5'd10: r = 28'sd16384;
			5'd11: r = 28'sd8192;
			5'd12: r = 28'sd4096;
			5'd13: r = 28'sd2048;
			5'd14: r = 28'sd1024;
			5'd15: r = 28'sd512;
			5'd16: r = 28'sd256;
			5'd17: r = 28'sd128;
			5'd18: r = 28'sd64;
			5'd19: r = 28'sd32;
			5'd20: r = 28'sd16;
			5'd21: r = 28'sd8;
			5'd22: r = 28'sd4;
			5'd23: r = 28'sd2;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Q.12 product back to Q3.12: round half up, saturate to 16 bits
	function automatic logic signed [VEL_W-1:0] round_sat(input logic signed [PRD_W-1:0] p);
		logic signed [PRD_W:0] s;
		logic signed [PRD_W-12:0] q;
		logic signed [VEL_W-1:0] r;
		s = (PRD_W+1)'(p) + 35'sd2048;
		q = s[PRD_W:12];
		if (q > 23'sd32767) begin
			r = 16'sh7fff;
		end else if (q < -23'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = q[VEL_W-1:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/gtp_if.sv
interface gtp_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [gtp_pkg::POS_W-1:0]     target_x;
	logic signed [gtp_pkg::POS_W-1:0]     target_y;
	logic signed [gtp_pkg::HDG_W-1:0]     target_heading;

	modport source (output valid, output target_x, output target_y,
		output target_heading, input ready);
	modport sink (input valid, input target_x, input target_y,
		input target_heading, output ready);
endinterface

interface gtp_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [gtp_pkg::VEL_W-1:0]     linear_velocity;
	logic signed [gtp_pkg::VEL_W-1:0]     angular_velocity;
	gtp_pkg::mode_t                       drive_mode;
	logic                                 arrived;

	modport source (output valid, output linear_velocity, output angular_velocity,
		output drive_mode, output arrived, input ready);
	modport sink (input valid, input linear_velocity, input angular_velocity,
		input drive_mode, input arrived, output ready);
endinterface

>>> rtl/go_to_pose_controller.sv
// channel    | dir | payload                                             | handshake
// in_ch      | in  | target_x, target_y, target_heading                  | valid/ready
// out_ch     | out | linear_velocity, angular_velocity, drive_mode, arr. | valid/ready
// cfg        | in  | cfg_index, cfg_data                                 | cfg_we only
//
// from accept: x squared, y squared, tolerance squared and the distance check; facing the
// target adds bearing search, first product, second product and second rounding; driving
// omits the second rounding; aligning skips the search; arrival goes straight to hand-off;
// the next transaction can be taken in the cycle after the load; in_ch.ready is high only
// while the sequencer idles; a finished result waits in the output register so the next
// transaction can be taken while it is held; out_ch.ready low stalls the sequencer only in
// its last step, when a new result must replace one still waiting
// arst_n clears the sequencer, the registers to their defaults and last_linear
module go_to_pose_controller #(
	parameter int unsigned CORDIC_STEPS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	gtp_in_if.sink                              in_ch,
	gtp_out_if.source                           out_ch,
	input  logic                                cfg_we,
	input  logic [gtp_pkg::IDX_W-1:0]           cfg_index,
	input  logic [gtp_pkg::CFG_W-1:0]           cfg_data
);

	// sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SQX  = 4'd1; // x squared
	localparam logic [3:0] ST_SQY  = 4'd2; // y squared
	localparam logic [3:0] ST_SQT  = 4'd3; // tolerance squared
	localparam logic [3:0] ST_CMP  = 4'd4; // distance check, pick branch
	localparam logic [3:0] ST_CORD = 4'd5; // bearing search
	localparam logic [3:0] ST_MA   = 4'd6; // first gain product
	localparam logic [3:0] ST_MB   = 4'd7; // second product, round first
	localparam logic [3:0] ST_MC   = 4'd8; // round second
	localparam logic [3:0] ST_DONE = 4'd9; // hand result to output register

	logic [3:0]                            state_q;

	// configuration registers
	logic [14:0]                           dist_tol_q;
	logic [13:0]                           angle_tol_q;
	logic [13:0]                           fwd_gain_q;
	logic [12:0]                           slow_q;
	logic [13:0]                           turn_gain_q;

	// item and working registers
	logic signed [gtp_pkg::POS_W-1:0]      x_q, y_q;
	logic signed [gtp_pkg::HDG_W-1:0]      h_q;
	logic [31:0]                           d2_q;
	logic signed [gtp_pkg::VEL_W-1:0]      b_q;
	logic signed [gtp_pkg::VEL_W-1:0]      lin_q, ang_q;
	gtp_pkg::mode_t                        mode_q;
	logic signed [gtp_pkg::VEL_W-1:0]      last_lin_q;

	// output register
	logic                                  ovalid_q;
	logic signed [gtp_pkg::VEL_W-1:0]      olin_q, oang_q;
	gtp_pkg::mode_t                        omode_q;
	logic                                  oarr_q;

	// shared multiplier
	logic signed [gtp_pkg::MOP_W-1:0]      mul_a, mul_b;
	logic signed [gtp_pkg::PRD_W-1:0]      prod_q;
	logic signed [gtp_pkg::VEL_W-1:0]      prod_rnd;

	// cordic
	logic                                  cord_start;
	gtp_pkg::cord_res_t                    cord_res;

	logic                                  in_take, out_take, out_load, far;
	logic signed [gtp_pkg::VEL_W-1:0]      h_ext;
	logic [gtp_pkg::VEL_W-1:0]             h_abs, b_abs;
	logic [gtp_pkg::VEL_W-1:0]             tol_ext;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_take     = in_ch.valid && in_ch.ready;
	assign out_take    = out_ch.valid && out_ch.ready;
	assign out_load    = (state_q == ST_DONE) && (!ovalid_q || out_ch.ready);

	// exact squared distance against squared tolerance
	assign far        = d2_q > prod_q[31:0];
	assign cord_start = (state_q == ST_CMP) && far;

	assign h_ext    = gtp_pkg::VEL_W'(h_q);
	assign h_abs    = h_ext[gtp_pkg::VEL_W-1] ? 16'(-h_ext) : 16'(h_ext);
	assign b_abs    = cord_res.bearing[gtp_pkg::VEL_W-1] ? 16'(-cord_res.bearing)
		: 16'(cord_res.bearing);
	assign tol_ext  = {2'b00, angle_tol_q};
	assign prod_rnd = gtp_pkg::round_sat(prod_q);

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SQX: begin
				mul_a = gtp_pkg::MOP_W'(x_q);
				mul_b = gtp_pkg::MOP_W'(x_q);
			end
			ST_SQY: begin
				mul_a = gtp_pkg::MOP_W'(y_q);
				mul_b = gtp_pkg::MOP_W'(y_q);
			end
			ST_SQT: begin
				mul_a = {2'b00, dist_tol_q};
				mul_b = {2'b00, dist_tol_q};
			end
			ST_MA: begin
				unique case (mode_q)
					gtp_pkg::MODE_FACE: begin
						mul_a = {4'b0000, slow_q};
						mul_b = gtp_pkg::MOP_W'(last_lin_q);
					end
					gtp_pkg::MODE_DRIVE: begin
						mul_a = {3'b000, fwd_gain_q};
						mul_b = gtp_pkg::MOP_W'(x_q);
					end
					gtp_pkg::MODE_ALIGN: begin
						mul_a = {3'b000, turn_gain_q};
						mul_b = gtp_pkg::MOP_W'(h_q);
					end
					default: begin
						mul_a = '0;
						mul_b = '0;
					end
				endcase
			end
			ST_MB: begin
				mul_a = {3'b000, turn_gain_q};
				mul_b = gtp_pkg::MOP_W'(b_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	gtp_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	gtp_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.x0     (x_q),
		.y0     (y_q),
		.res    (cord_res)
	);

	// configuration writes, index beyond the list is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_tol_q  <= gtp_pkg::RST_DIST_TOL;
			angle_tol_q <= gtp_pkg::RST_ANGLE_TOL;
			fwd_gain_q  <= gtp_pkg::RST_FWD_GAIN;
			slow_q      <= gtp_pkg::RST_SLOW;
			turn_gain_q <= gtp_pkg::RST_TURN_GAIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gtp_pkg::REG_DIST_TOL:  dist_tol_q  <= cfg_data[14:0];
				gtp_pkg::REG_ANGLE_TOL: angle_tol_q <= cfg_data[13:0];
				gtp_pkg::REG_FWD_GAIN:  fwd_gain_q  <= cfg_data[13:0];
				gtp_pkg::REG_SLOW:      slow_q      <= cfg_data[12:0];
				gtp_pkg::REG_TURN_GAIN: turn_gain_q <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	// control: sequencer, kept linear command, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			last_lin_q <= '0;
			ovalid_q   <= 1'b0;
		end else begin
			if (out_load) begin
				ovalid_q   <= 1'b1;
				last_lin_q <= lin_q;
			end else if (out_take) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (in_take) state_q <= ST_SQX;
				ST_SQX:  state_q <= ST_SQY;
				ST_SQY:  state_q <= ST_SQT;
				ST_SQT:  state_q <= ST_CMP;
				ST_CMP: begin
					if (far) begin
						state_q <= ST_CORD;
					end else if (h_abs > tol_ext) begin
						state_q <= ST_MA;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_CORD: if (cord_res.done) state_q <= ST_MA;
				ST_MA:   state_q <= ST_MB;
				ST_MB:   state_q <= (mode_q == gtp_pkg::MODE_FACE) ? ST_MC : ST_DONE;
				ST_MC:   state_q <= ST_DONE;
				ST_DONE: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			x_q <= in_ch.target_x;
			y_q <= in_ch.target_y;
			h_q <= in_ch.target_heading;
		end
		if (state_q == ST_SQY) begin
			d2_q <= prod_q[31:0];
		end
		if (state_q == ST_SQT) begin
			d2_q <= d2_q + prod_q[31:0];
		end
		if (state_q == ST_CMP) begin
			lin_q <= '0;
			ang_q <= '0;
			if (far) begin
				mode_q <= gtp_pkg::MODE_FACE;
			end else if (h_abs > tol_ext) begin
				mode_q <= gtp_pkg::MODE_ALIGN;
			end else begin
				mode_q <= gtp_pkg::MODE_ARRIVED;
			end
		end
		if ((state_q == ST_CORD) && cord_res.done) begin
			b_q <= cord_res.bearing;
			mode_q <= (b_abs > tol_ext) ? gtp_pkg::MODE_FACE : gtp_pkg::MODE_DRIVE;
		end
		if (state_q == ST_MB) begin
			if (mode_q == gtp_pkg::MODE_ALIGN) begin
				ang_q <= prod_rnd;
			end else begin
				lin_q <= prod_rnd;
			end
		end
		if (state_q == ST_MC) begin
			ang_q <= prod_rnd;
		end
		if (out_load) begin
			olin_q  <= lin_q;
			oang_q  <= ang_q;
			omode_q <= mode_q;
			oarr_q  <= (mode_q == gtp_pkg::MODE_ARRIVED);
		end
	end

	assign out_ch.valid            = ovalid_q;
	assign out_ch.linear_velocity  = olin_q;
	assign out_ch.angular_velocity = oang_q;
	assign out_ch.drive_mode       = omode_q;
	assign out_ch.arrived          = oarr_q;

`ifndef SYNTHESIS
	a_arrived_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.arrived == (out_ch.drive_mode == gtp_pkg::MODE_ARRIVED)))
		else $error("arrived flag disagrees with drive mode");
	a_stop_linear: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (out_ch.drive_mode == gtp_pkg::MODE_ALIGN
		|| out_ch.drive_mode == gtp_pkg::MODE_ARRIVED) |-> (out_ch.linear_velocity == 0))
		else $error("linear command while within distance");
	a_drive_no_turn: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (out_ch.drive_mode == gtp_pkg::MODE_DRIVE)
		|-> (out_ch.angular_velocity == 0))
		else $error("turn command while driving forward");
	a_cord_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		cord_res.done |-> (state_q == ST_CORD))
		else $error("bearing finished outside the search step");
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> !in_ch.ready)
		else $error("new transaction taken while one is in work");
`endif

endmodule

>>> rtl/gtp_mul.sv
module gtp_mul (
	input  logic                                  clk,
	input  logic signed [gtp_pkg::MOP_W-1:0]      a,
	input  logic signed [gtp_pkg::MOP_W-1:0]      b,
	output logic signed [gtp_pkg::PRD_W-1:0]      p_q
);

	// registered 17x17 signed product
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

>>> rtl/gtp_cordic.sv
module gtp_cordic #(
	parameter int unsigned STEPS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [gtp_pkg::POS_W-1:0]  x0,
	input  logic signed [gtp_pkg::POS_W-1:0]  y0,
	output gtp_pkg::cord_res_t                res
);

	localparam int unsigned CW = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic                                 busy_q;
	logic                                 done_q;
	logic [CW-1:0]                        cnt_q;
	logic signed [gtp_pkg::CXY_W-1:0]     x_q, y_q;
	logic signed [gtp_pkg::CZ_W-1:0]      z_q;
	logic signed [gtp_pkg::CXY_W-1:0]     xs, ys, dx, dy;
	logic signed [gtp_pkg::CZ_W-1:0]      zr, atan_v;
	logic                                 last;

	// operands scaled by 2^14
	assign xs = {{4{x0[gtp_pkg::POS_W-1]}}, x0, 14'b0};
	assign ys = {{4{y0[gtp_pkg::POS_W-1]}}, y0, 14'b0};

	assign dx     = y_q >>> cnt_q;
	assign dy     = x_q >>> cnt_q;
	assign atan_v = gtp_pkg::atan_entry(gtp_pkg::ATAN_IDX_W'(cnt_q));
	assign last   = (cnt_q == CW'(STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// quarter-turn pre-rotation for the left half plane, then vectoring steps
	always_ff @(posedge clk) begin
		if (start) begin
			if (x0 < 0) begin
				if (y0 >= 0) begin
					x_q <= ys;
					y_q <= -xs;
					z_q <= gtp_pkg::ANG_PI_HALF;
				end else begin
					x_q <= -ys;
					y_q <= xs;
					z_q <= -gtp_pkg::ANG_PI_HALF;
				end
			end else begin
				x_q <= xs;
				y_q <= ys;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_v;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_v;
			end
		end
	end

	assign zr          = z_q + 28'sd2048;
	assign res.done    = done_q;
	assign res.bearing = zr[gtp_pkg::CZ_W-1:12];

`ifndef SYNTHESIS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("cordic done without a running pass");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !last |=> busy_q)
		else $error("cordic pass ended early");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("cordic done held more than one cycle");
`endif

endmodule
